// ===== rtl/core/can_message_segmenter_assert.svh =====
// Assertion macros for the message segmenter checker.
`ifndef CAN_MESSAGE_SEGMENTER_ASSERT_SVH
`define CAN_MESSAGE_SEGMENTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("segmenter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("segmenter assertion failed");

`endif

// ===== rtl/core/cms_pkg.sv =====
// Types and constants for the CAN message segmenter.
package cms_pkg;

	localparam int unsigned PAYLOAD_PER_FRAME = 7;
	localparam int unsigned STORE_DEPTH = 7;
	localparam int unsigned FILL_W = 3;

	typedef enum logic [1:0] {
		PH_ADDR    = 2'd0,
		PH_FUNC    = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} msg_t;

	typedef struct packed {
		logic [7:0] dest_address;
		logic [7:0] packet_index;
		logic [3:0] frame_length;
		logic [7:0] frame_byte0;
		logic [7:0] frame_byte1;
		logic [7:0] frame_byte2;
		logic [7:0] frame_byte3;
		logic [7:0] frame_byte4;
		logic [7:0] frame_byte5;
		logic [7:0] frame_byte6;
		logic [7:0] frame_byte7;
		logic       final_frame;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} offer_t;

endpackage

// ===== rtl/core/cms_core.sv =====
// Input register, message state and frame assembly of the segmenter.
module cms_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_stall,
	input  cms_pkg::msg_t  msg,
	input  logic           advance,
	output cms_pkg::offer_t offer
);

	logic                          valid_s1;
	cms_pkg::msg_t                 msg_s1;
	cms_pkg::phase_t               phase_q, phase_d;
	logic [7:0]                    addr_q, addr_d;
	logic [7:0]                    func_q, func_d;
	logic [cms_pkg::FILL_W-1:0]    fill_q, fill_d, fill_inc;
	logic [7:0]                    cnt_q, cnt_d;
	logic [7:0]                    store_q [cms_pkg::STORE_DEPTH];
	logic [7:0]                    pay [cms_pkg::STORE_DEPTH];
	logic                          take;
	logic                          wr_en;
	logic                          emit;

	assign take = valid_s1 && advance;
	assign msg_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!msg_stall) begin
			valid_s1 <= msg_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_valid && !msg_stall) begin
			msg_s1 <= msg;
		end
	end

	always_comb begin
		phase_d = phase_q;
		addr_d = addr_q;
		func_d = func_q;
		fill_d = fill_q;
		cnt_d = cnt_q;
		wr_en = 1'b0;
		emit = 1'b0;
		fill_inc = fill_q;
		case (phase_q)
			cms_pkg::PH_ADDR: begin
				addr_d = msg_s1.data_byte;
				fill_d = '0;
				cnt_d = '0;
				phase_d = msg_s1.last_byte ? cms_pkg::PH_ADDR : cms_pkg::PH_FUNC;
			end
			cms_pkg::PH_FUNC: begin
				func_d = msg_s1.data_byte;
				if (msg_s1.last_byte) begin
					phase_d = cms_pkg::PH_ADDR;
					fill_d = '0;
					cnt_d = '0;
				end else begin
					phase_d = cms_pkg::PH_PAYLOAD;
				end
			end
			default: begin
				wr_en = (fill_q < cms_pkg::FILL_W'(cms_pkg::STORE_DEPTH));
				fill_inc = wr_en ? fill_q + 1'b1 : fill_q;
				emit = (fill_inc >= cms_pkg::FILL_W'(cms_pkg::PAYLOAD_PER_FRAME))
					|| msg_s1.last_byte;
				if (emit) begin
					fill_d = '0;
					cnt_d = msg_s1.last_byte ? 8'd0 : cnt_q + 8'd1;
					if (msg_s1.last_byte) begin
						phase_d = cms_pkg::PH_ADDR;
					end
				end else begin
					fill_d = fill_inc;
				end
			end
		endcase
	end

	always_comb begin
		for (int j = 0; j < cms_pkg::STORE_DEPTH; j++) begin
			if (cms_pkg::FILL_W'(j) < fill_q) begin
				pay[j] = store_q[j];
			end else if (cms_pkg::FILL_W'(j) == fill_q && wr_en) begin
				pay[j] = msg_s1.data_byte;
			end else begin
				pay[j] = 8'd0;
			end
		end
	end

	always_comb begin
		offer.valid = valid_s1 && emit;
		offer.frame.dest_address = addr_q;
		offer.frame.packet_index = cnt_q;
		offer.frame.frame_length = {1'b0, fill_inc} + 4'd1;
		offer.frame.frame_byte0 = func_q;
		offer.frame.frame_byte1 = pay[0];
		offer.frame.frame_byte2 = pay[1];
		offer.frame.frame_byte3 = pay[2];
		offer.frame.frame_byte4 = pay[3];
		offer.frame.frame_byte5 = pay[4];
		offer.frame.frame_byte6 = pay[5];
		offer.frame.frame_byte7 = pay[6];
		offer.frame.final_frame = msg_s1.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cms_pkg::PH_ADDR;
			addr_q <= '0;
			func_q <= '0;
			fill_q <= '0;
			cnt_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			addr_q <= addr_d;
			func_q <= func_d;
			fill_q <= fill_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			store_q[fill_q] <= msg_s1.data_byte;
		end
	end

endmodule

// ===== rtl/core/cms_out_reg.sv =====
// Result register that holds a finished frame until the receiver takes it.
module cms_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  cms_pkg::offer_t offer,
	output logic            advance,
	output logic            frame_valid,
	input  logic            frame_stall,
	output cms_pkg::frame_t frame
);

	logic            valid_q;
	cms_pkg::frame_t frame_q;

	assign advance = !valid_q || !frame_stall;
	assign frame_valid = valid_q;
	assign frame = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= offer.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && offer.valid) begin
			frame_q <= offer.frame;
		end
	end

endmodule

// ===== rtl/core/can_message_segmenter.sv =====
// Top level of the CAN message segmenter.
// The msg channel carries one message byte per beat with a last-byte flag. The first
// byte of a message is the destination address, the second the function code, and the
// rest is payload. The frame channel carries one CAN frame per beat: address, packet
// number, length code, the function code in byte 0, up to seven payload bytes with
// zero fill, and a flag on the last frame of the message.
// A byte beat is registered in the input register on acceptance and processed from
// there; the frame it completes becomes valid once loaded into the result register.
// One byte is accepted every cycle while no held frame stalls the frame channel; the
// message state is updated between the input register and the result register.
// Reset clears the message state, so the next byte is taken as an address.
// While the frame channel is stalled with a frame held, that frame stays put; one more
// byte can enter the input register, and the byte channel then stalls until the held
// frame is taken.
module can_message_segmenter (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            msg_valid,
	output logic            msg_stall,
	input  cms_pkg::msg_t   msg,
	output logic            frame_valid,
	input  logic            frame_stall,
	output cms_pkg::frame_t frame
);

	cms_pkg::offer_t offer;
	logic            advance;

	cms_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.advance   (advance),
		.offer     (offer)
	);

	cms_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.offer       (offer),
		.advance     (advance),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame)
	);

endmodule

// ===== rtl/core/cms_checker.sv =====
// Port-level checks for the CAN message segmenter and their binding.
`include "can_message_segmenter_assert.svh"

module cms_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            msg_valid,
	input logic            msg_stall,
	input cms_pkg::msg_t   msg,
	input logic            frame_valid,
	input logic            frame_stall,
	input cms_pkg::frame_t frame
);

	`CMS_ASSERT_NEXT(a_frame_hold, clk, arst_n, frame_valid && frame_stall, frame_valid)
	`CMS_ASSERT_NEXT(a_frame_stable, clk, arst_n, frame_valid && frame_stall, $stable(frame))
	`CMS_ASSERT_NOW(a_stall_cause, clk, arst_n, msg_stall, frame_valid && frame_stall)
	`CMS_ASSERT_NOW(a_length, clk, arst_n, frame_valid, frame.frame_length >= 4'd2 && frame.frame_length <= 4'd8)

endmodule

bind can_message_segmenter cms_checker u_cms_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.msg_valid   (msg_valid),
	.msg_stall   (msg_stall),
	.msg         (msg),
	.frame_valid (frame_valid),
	.frame_stall (frame_stall),
	.frame       (frame)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for can_message_segmenter: byte-stream stimulus with frame prediction.
module testbench;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int HOLD_CYCLES = 400;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            msg_valid = 1'b0;
	logic            msg_stall;
	cms_pkg::msg_t   msg = '0;
	logic            frame_valid;
	logic            frame_stall = 1'b0;
	cms_pkg::frame_t frame;

	cms_pkg::phase_t seg_phase = cms_pkg::PH_ADDR;
	logic [7:0]      seg_address = '0;
	logic [7:0]      seg_function = '0;
	logic [7:0]      seg_store [cms_pkg::STORE_DEPTH];
	int              seg_fill = 0;
	logic [7:0]      seg_packet = '0;

	cms_pkg::frame_t frames_due[$];
	int     errors = 0;
	int     bytes_accepted = 0;
	int     cycle_count = 0;
	int     hold_left = 0;
	int     hold_req = 0;
	int     hold_seen = 0;
	int     stall_pct = 0;
	int     idle_pct = 0;
	int     stall_run = 0;
	logic   stall_now = 1'b0;

	can_message_segmenter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_stall  (msg_stall),
		.msg        (msg),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame      (frame)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(0, 2);
		end else if (r < 95) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 60);
	endfunction

	// Advance the segmentation state by one byte and queue the frame it completes.
	function automatic void segment_byte(cms_pkg::msg_t m);
		cms_pkg::frame_t f;
		logic [7:0]      b [cms_pkg::STORE_DEPTH];
		case (seg_phase)
			cms_pkg::PH_ADDR: begin
				seg_address = m.data_byte;
				seg_fill = 0;
				seg_packet = '0;
				seg_phase = m.last_byte ? cms_pkg::PH_ADDR : cms_pkg::PH_FUNC;
			end
			cms_pkg::PH_FUNC: begin
				seg_function = m.data_byte;
				seg_phase = m.last_byte ? cms_pkg::PH_ADDR : cms_pkg::PH_PAYLOAD;
				if (m.last_byte) begin
					seg_fill = 0;
					seg_packet = '0;
				end
			end
			default: begin
				if (seg_fill < cms_pkg::STORE_DEPTH) begin
					seg_store[seg_fill] = m.data_byte;
					seg_fill++;
				end
				if (seg_fill >= cms_pkg::PAYLOAD_PER_FRAME || m.last_byte) begin
					for (int j = 0; j < cms_pkg::STORE_DEPTH; j++) begin
						b[j] = (j < seg_fill) ? seg_store[j] : 8'h00;
					end
					f.dest_address = seg_address;
					f.packet_index = seg_packet;
					f.frame_length = 4'(seg_fill + 1);
					f.frame_byte0 = seg_function;
					f.frame_byte1 = b[0];
					f.frame_byte2 = b[1];
					f.frame_byte3 = b[2];
					f.frame_byte4 = b[3];
					f.frame_byte5 = b[4];
					f.frame_byte6 = b[5];
					f.frame_byte7 = b[6];
					f.final_frame = m.last_byte;
					frames_due.push_back(f);
					seg_packet = seg_packet + 8'd1;
					seg_fill = 0;
					if (m.last_byte) begin
						seg_phase = cms_pkg::PH_ADDR;
						seg_packet = '0;
					end
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		errors++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s got %02h expected %02h", name, got, want));
		end
	endtask

	task automatic check_frame(input cms_pkg::frame_t got);
		cms_pkg::frame_t want;
		if (frames_due.size() == 0) begin
			report_mismatch("frame arrived with none expected");
			return;
		end
		want = frames_due.pop_front();
		compare_field("dest_address", got.dest_address, want.dest_address);
		compare_field("packet_index", got.packet_index, want.packet_index);
		compare_field("frame_length", 8'(got.frame_length), 8'(want.frame_length));
		compare_field("frame_byte0", got.frame_byte0, want.frame_byte0);
		compare_field("frame_byte1", got.frame_byte1, want.frame_byte1);
		compare_field("frame_byte2", got.frame_byte2, want.frame_byte2);
		compare_field("frame_byte3", got.frame_byte3, want.frame_byte3);
		compare_field("frame_byte4", got.frame_byte4, want.frame_byte4);
		compare_field("frame_byte5", got.frame_byte5, want.frame_byte5);
		compare_field("frame_byte6", got.frame_byte6, want.frame_byte6);
		compare_field("frame_byte7", got.frame_byte7, want.frame_byte7);
		compare_field("final_frame", 8'(got.final_frame), 8'(want.final_frame));
	endtask

	// Offer one byte beat and return at the edge that accepts it.
	task automatic send_byte(input logic [7:0] data, input logic last);
		cms_pkg::msg_t m;
		int            gap;
		m.data_byte = data;
		m.last_byte = last;
		gap = ($urandom_range(0, 99) < idle_pct) ? pick_gap() + 1 : 0;
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= m;
		do @(posedge clk); while (msg_stall);
		segment_byte(m);
		bytes_accepted++;
	endtask

	task automatic send_message(input int payload_len);
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_byte(8'($urandom_range(0, 255)), payload_len == 0);
		for (int i = 1; i <= payload_len; i++) begin
			send_byte(8'($urandom_range(0, 255)), i == payload_len);
		end
	endtask

	task automatic test_directed();
		stall_pct = 0;
		idle_pct = 0;
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
		for (int i = 0; i < 7; i++) begin
			send_byte(i[0] ? 8'hFF : 8'h00, i == 6);
		end
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		for (int i = 0; i < 8; i++) begin
			send_byte(8'h01 << i, i == 7);
		end
	endtask

	task automatic test_random_messages(input int count, input int stall, input int idle);
		int start;
		int r;
		stall_pct = stall;
		idle_pct = idle;
		start = bytes_accepted;
		while (bytes_accepted - start < count) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				send_message(($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
						: $urandom_range(1, 14));
			end else if (r < 90) begin
				send_byte(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				send_message(0);
			end
		end
	endtask

	task automatic test_backpressure();
		stall_pct = 0;
		idle_pct = 0;
		@(posedge clk);
		hold_req++;
		for (int i = 0; i < 6; i++) begin
			send_message($urandom_range(10, 30));
		end
	endtask

	task automatic test_full_rate();
		stall_pct = 0;
		idle_pct = 0;
		for (int i = 0; i < 12; i++) begin
			send_message($urandom_range(1, 21));
		end
	endtask

	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && frame_valid && !frame_stall) begin
				check_frame(frame);
			end
			if (stall_run > 0) begin
				stall_run--;
			end else begin
				stall_now = $urandom_range(0, 99) < stall_pct;
				stall_run = pick_gap();
			end
			frame_stall <= (hold_left > 0) || stall_now;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("can_message_segmenter regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_messages(500, 30, 30);
		test_backpressure();
		test_full_rate();
		test_random_messages(400, 20, 40);
		msg_valid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("can_message_segmenter regression: pass");
		end else begin
			$display("can_message_segmenter regression: fail");
		end
		$finish;
	end

endmodule
